@@ rtl/etdq_pkg.sv @@
// Shared types, codes and default sizes for the event table dispatch queue.
// No dependencies; compiled first.
package etdq_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int ARG_WIDTH_DEF   = 32;

  localparam int REQ_WIDTH       = 4;
  localparam int EVENT_WIDTH     = 7;
  localparam int CFG_WIDTH       = 7;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int ERR_WIDTH       = 3;

  typedef enum logic [REQ_WIDTH-1:0] {
    REQ_BIND       = 4'd0,
    REQ_UNBIND     = 4'd1,
    REQ_ENABLE     = 4'd2,
    REQ_DISABLE    = 4'd3,
    REQ_QUERY      = 4'd4,
    REQ_TRIGGER    = 4'd5,
    REQ_DISPATCH   = 4'd6,
    REQ_READ_ERROR = 4'd7,
    REQ_Q_ON       = 4'd8,
    REQ_Q_OFF      = 4'd9,
    REQ_Q_CLEAR    = 4'd10
  } req_t;

  typedef enum logic [ERR_WIDTH-1:0] {
    ERR_NONE       = 3'd0,
    ERR_RANGE      = 3'd1,
    ERR_FULL       = 3'd2,
    ERR_DISABLED   = 3'd3,
    ERR_NO_HANDLER = 3'd4
  } err_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_TABLE_SIZE    = 2'd0,
    CFG_QUEUE_SIZE    = 2'd1,
    CFG_HANDLER_BOUND = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    TBL_NONE,
    TBL_BIND,
    TBL_UNBIND,
    TBL_ENABLE,
    TBL_DISABLE
  } tbl_op_t;

  // load: request leaves the decode stage this cycle
  typedef struct packed {
    logic    load;
    tbl_op_t op;
    logic    rd_req;
  } tbl_cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_cmd_t;

endpackage

@@ rtl/etdq_if.sv @@
// Channel interfaces: request words, result words and config writes.
// Depends on etdq_pkg.
interface etdq_req_if import etdq_pkg::*; #(
  parameter int ARG_WIDTH = ARG_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [REQ_WIDTH-1:0]          req_type;
  logic signed [EVENT_WIDTH-1:0] event_num;
  logic [ARG_WIDTH-1:0]          ptr_arg_a;
  logic [ARG_WIDTH-1:0]          ptr_arg_b;
  logic signed [ARG_WIDTH-1:0]   int_arg_a;
  logic signed [ARG_WIDTH-1:0]   int_arg_b;

  modport source (output valid, req_type, event_num, ptr_arg_a, ptr_arg_b, int_arg_a,
                  int_arg_b, input ready);
  modport sink (input valid, req_type, event_num, ptr_arg_a, ptr_arg_b, int_arg_a,
                int_arg_b, output ready);
endinterface

interface etdq_rsp_if import etdq_pkg::*; #(
  parameter int ARG_WIDTH       = ARG_WIDTH_DEF,
  parameter int EVENT_IDX_WIDTH = $clog2(TABLE_DEPTH_DEF)
) ();
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic                        is_on;
  logic [ERR_WIDTH-1:0]        error_code;
  logic                        dispatched;
  logic [EVENT_IDX_WIDTH-1:0]  out_event;
  logic [ARG_WIDTH-1:0]        out_ptr_a;
  logic [ARG_WIDTH-1:0]        out_ptr_b;
  logic signed [ARG_WIDTH-1:0] out_int_a;
  logic signed [ARG_WIDTH-1:0] out_int_b;

  modport source (output valid, ok, is_on, error_code, dispatched, out_event, out_ptr_a,
                  out_ptr_b, out_int_a, out_int_b, input ready);
  modport sink (input valid, ok, is_on, error_code, dispatched, out_event, out_ptr_a,
                out_ptr_b, out_int_a, out_int_b, output ready);
endinterface

interface etdq_cfg_if import etdq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_WIDTH-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/event_table_dispatch_queue.sv @@
// Top level of the event table dispatch queue: request decode, config and
// sticky error. Depends on etdq_pkg, etdq_if, etdq_ring and etdq_table.
//
// Usage:
//   req : request words (req_type, event_num, four bind arguments), valid/ready.
//   rsp : one result word per request (ok, is_on, error_code, dispatched and
//         the dispatched event with its arguments), valid/ready.
//   cfg : register writes (index 0 table_size, 1 queue_size, 2 handler_bound);
//         ready is always high. Write only while no request is in flight.
//         Writing queue_size empties the queue.
// Timing: an accepted request is held in the decode register and then loads
//   the result register, which drives rsp.valid; a held-off rsp keeps it waiting
//   in the decode register. One request per cycle is taken while rsp is not held
//   off: the decode logic between the input register and the result register
//   does the whole request, and the table argument memory is read on the same
//   edge the result loads.
// Stall: while rsp is held off the result stays put; one more request may wait
//   in the decode register, and req.ready drops once both are full.
// Reset (rst, synchronous): empty queue, queue off, no error, all entries
//   disabled with zero arguments, config and valid registers zero. No clearing pass.
module event_table_dispatch_queue import etdq_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ARG_WIDTH   = ARG_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  etdq_req_if.sink    req,
  etdq_rsp_if.source  rsp,
  etdq_cfg_if.sink    cfg
);

  localparam int TIW = $clog2(TABLE_DEPTH);
  // compare widths: wide enough for the 7-bit registers and for the depths
  localparam int TCW = (CFG_WIDTH > $clog2(TABLE_DEPTH + 1)) ? CFG_WIDTH
                                                             : $clog2(TABLE_DEPTH + 1);
  localparam int QCW = (CFG_WIDTH > $clog2(QUEUE_DEPTH + 1)) ? CFG_WIDTH
                                                             : $clog2(QUEUE_DEPTH + 1);
  localparam int FCW = $clog2(QUEUE_DEPTH + 1);

  // ---------------- config registers ----------------
  logic [CFG_WIDTH-1:0] table_size;
  logic [CFG_WIDTH-1:0] queue_size;
  logic                 handler_bound;
  logic                 cfg_fire;
  logic                 cfg_queue_wr;

  assign cfg.ready    = 1'b1;
  assign cfg_fire     = cfg.valid && cfg.ready;
  assign cfg_queue_wr = cfg_fire && cfg_idx_t'(cfg.index) == CFG_QUEUE_SIZE;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size    <= '0;
      queue_size    <= '0;
      handler_bound <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_TABLE_SIZE:    table_size    <= cfg.data;
        CFG_QUEUE_SIZE:    queue_size    <= cfg.data;
        CFG_HANDLER_BOUND: handler_bound <= cfg.data[0];
        default: ;   // writes past the list are dropped
      endcase
    end
  end

  // sizes in use, saturated at the physical depths
  logic [TCW-1:0] eff_table;
  logic [QCW-1:0] eff_queue;

  assign eff_table = (TCW'(table_size) > TCW'(TABLE_DEPTH)) ? TCW'(TABLE_DEPTH)
                                                            : TCW'(table_size);
  assign eff_queue = (QCW'(queue_size) > QCW'(QUEUE_DEPTH)) ? QCW'(QUEUE_DEPTH)
                                                            : QCW'(queue_size);

  // ---------------- decode (input) register ----------------
  logic                          a_valid;
  req_t                          a_req;
  logic signed [EVENT_WIDTH-1:0] a_event;
  logic [ARG_WIDTH-1:0]          a_ptr_a, a_ptr_b;
  logic signed [ARG_WIDTH-1:0]   a_int_a, a_int_b;
  logic                          a_fire;
  logic                          res_valid;

  assign a_fire    = a_valid && (!res_valid || rsp.ready);
  assign req.ready = !a_valid || a_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req.ready) begin
      a_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      a_req   <= req_t'(req.req_type);
      a_event <= req.event_num;
      a_ptr_a <= req.ptr_arg_a;
      a_ptr_b <= req.ptr_arg_b;
      a_int_a <= req.int_arg_a;
      a_int_b <= req.int_arg_b;
    end
  end

  // ---------------- event number resolve ----------------
  // negative numbers count back from the table end; -size < e < size is valid
  logic                   ev_neg;
  logic [EVENT_WIDTH-1:0] ev_mag;
  logic [TCW-1:0]         ev_mag_ext;
  logic                   in_range;
  logic [TIW-1:0]         req_idx;

  assign ev_neg     = a_event[EVENT_WIDTH-1];
  assign ev_mag     = ev_neg ? EVENT_WIDTH'(-a_event) : EVENT_WIDTH'(a_event);
  assign ev_mag_ext = TCW'(ev_mag);
  assign in_range   = ev_mag_ext < eff_table;
  assign req_idx    = ev_neg ? TIW'(eff_table - ev_mag_ext) : TIW'(ev_mag_ext);

  // ---------------- ring and table ----------------
  ring_cmd_t         ring_cmd;
  logic [TIW-1:0]    ring_head;
  logic [FCW-1:0]    ring_count;
  tbl_cmd_t          tbl_cmd;
  logic              idx_enabled;
  logic              head_enabled;
  logic [4*ARG_WIDTH-1:0] tbl_args;
  logic              queue_full;
  logic              head_live;

  assign queue_full = QCW'(ring_count) >= eff_queue;
  // a popped index at or beyond the current table size counts as disabled
  assign head_live  = (TCW'(ring_head) < eff_table) && head_enabled;

  etdq_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_WIDTH  (TIW)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ring_cmd),
    .push_data (req_idx),
    .eff_size  (eff_queue),
    .head      (ring_head),
    .count     (ring_count)
  );

  etdq_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ARG_WIDTH   (ARG_WIDTH)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .cmd        (tbl_cmd),
    .wr_idx     (req_idx),
    .wr_args    ({a_ptr_a, a_ptr_b, a_int_a, a_int_b}),
    .rd_idx     (ring_head),
    .wr_enabled (idx_enabled),
    .rd_enabled (head_enabled),
    .rd_args    (tbl_args)
  );

  // ---------------- request decode ----------------
  err_t    sticky, sticky_next;
  logic    queue_on, queue_on_next;
  logic    ok_n, is_on_n, disp_n;
  err_t    code_n;
  tbl_op_t op_n;
  logic    push_n, pop_n, clear_n, rd_req_n;

  always_comb begin
    ok_n          = 1'b0;
    is_on_n       = 1'b0;
    code_n        = ERR_NONE;
    disp_n        = 1'b0;
    sticky_next   = sticky;
    queue_on_next = queue_on;
    op_n          = TBL_NONE;
    push_n        = 1'b0;
    pop_n         = 1'b0;
    clear_n       = 1'b0;
    rd_req_n      = 1'b0;
    if (a_req == REQ_READ_ERROR) begin
      ok_n        = 1'b1;
      code_n      = sticky;
      sticky_next = ERR_NONE;
    end else if (sticky == ERR_NONE) begin
      // any pending error blocks everything but the error read
      unique case (a_req) inside
        REQ_BIND, REQ_UNBIND, REQ_ENABLE, REQ_DISABLE, REQ_QUERY: begin
          if (!in_range) begin
            sticky_next = ERR_RANGE;
          end else begin
            ok_n = 1'b1;
            unique case (a_req)
              REQ_BIND:    op_n = TBL_BIND;
              REQ_UNBIND:  op_n = TBL_UNBIND;
              REQ_ENABLE:  op_n = TBL_ENABLE;
              REQ_DISABLE: op_n = TBL_DISABLE;
              default:     is_on_n = idx_enabled;
            endcase
          end
        end
        REQ_TRIGGER: begin
          // range, then full, then disabled; pushes even with the queue off
          if (!in_range) begin
            sticky_next = ERR_RANGE;
          end else if (queue_full) begin
            sticky_next = ERR_FULL;
          end else if (!idx_enabled) begin
            sticky_next = ERR_DISABLED;
          end else begin
            push_n = 1'b1;
            ok_n   = 1'b1;
          end
        end
        REQ_DISPATCH: begin
          // queue off or empty: quiet no-op
          if (queue_on && ring_count != '0) begin
            pop_n = 1'b1;
            if (!head_live) begin
              ok_n = 1'b1;
            end else if (!handler_bound) begin
              queue_on_next = 1'b0;
              sticky_next   = ERR_NO_HANDLER;
            end else begin
              ok_n     = 1'b1;
              disp_n   = 1'b1;
              rd_req_n = 1'b1;
            end
          end
        end
        REQ_Q_ON: begin
          queue_on_next = 1'b1;
          ok_n          = 1'b1;
        end
        REQ_Q_OFF: begin
          queue_on_next = 1'b0;
          ok_n          = 1'b1;
        end
        REQ_Q_CLEAR: begin
          clear_n = 1'b1;
          ok_n    = 1'b1;
        end
        default: ;   // unknown codes: ok stays low
      endcase
    end
  end

  assign ring_cmd.push  = a_fire && push_n;
  assign ring_cmd.pop   = a_fire && pop_n;
  assign ring_cmd.clear = (a_fire && clear_n) || cfg_queue_wr;
  assign tbl_cmd.load   = a_fire;
  assign tbl_cmd.op     = op_n;
  assign tbl_cmd.rd_req = rd_req_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      sticky   <= ERR_NONE;
      queue_on <= 1'b0;
    end else if (a_fire) begin
      sticky   <= sticky_next;
      queue_on <= queue_on_next;
    end
  end

  // ---------------- result register ----------------
  logic           res_ok, res_is_on, res_disp;
  err_t           res_code;
  logic [TIW-1:0] res_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (a_fire) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      res_ok    <= ok_n;
      res_is_on <= is_on_n;
      res_code  <= code_n;
      res_disp  <= disp_n;
      res_event <= disp_n ? ring_head : '0;
    end
  end

  // argument fields come straight from the table's registered read,
  // already zero unless this word dispatched a bound entry
  assign rsp.valid      = res_valid;
  assign rsp.ok         = res_ok;
  assign rsp.is_on      = res_is_on;
  assign rsp.error_code = res_code;
  assign rsp.dispatched = res_disp;
  assign rsp.out_event  = res_event;
  assign rsp.out_ptr_a  = tbl_args[4*ARG_WIDTH-1 -: ARG_WIDTH];
  assign rsp.out_ptr_b  = tbl_args[3*ARG_WIDTH-1 -: ARG_WIDTH];
  assign rsp.out_int_a  = $signed(tbl_args[2*ARG_WIDTH-1 -: ARG_WIDTH]);
  assign rsp.out_int_b  = $signed(tbl_args[ARG_WIDTH-1 -: ARG_WIDTH]);

`ifndef SYNTHESIS
  // fill count never passes the ring depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= FCW'(QUEUE_DEPTH))
    else $error("ring fill count above depth");

  // no push into a full queue, no pop from an empty one
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ring_cmd.push |-> (QCW'(ring_count) < eff_queue))
    else $error("push into full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ring_cmd.pop |-> (ring_count != '0))
    else $error("pop from empty queue");

  // an error read leaves no error behind
  a_err_cleared: assert property (@(posedge clk) disable iff (rst)
    (a_fire && a_req == REQ_READ_ERROR) |=> (sticky == ERR_NONE))
    else $error("sticky error survived read");

  // a dispatched word is always a successful one
  a_disp_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.dispatched) |-> rsp.ok)
    else $error("dispatched without ok");
`endif

endmodule

@@ rtl/etdq_ring.sv @@
// Pending-event ring: slot pointers, fill count and ring memory with a
// registered head read. Depends on etdq_pkg.
module etdq_ring import etdq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int DATA_WIDTH  = $clog2(TABLE_DEPTH_DEF),
  localparam int QIW = $clog2(QUEUE_DEPTH),
  localparam int QCW = (CFG_WIDTH > $clog2(QUEUE_DEPTH + 1)) ? CFG_WIDTH
                                                             : $clog2(QUEUE_DEPTH + 1),
  localparam int FCW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ring_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic [QCW-1:0]        eff_size,
  output logic [DATA_WIDTH-1:0] head,
  output logic [FCW-1:0]        count
);

  logic [DATA_WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [QIW-1:0]        wr_slot, wr_slot_next;
  logic [QIW-1:0]        rd_slot, rd_slot_next;
  logic [FCW-1:0]        count_next;

  // wraps at the configured size; size zero pins the slot at 0
  function automatic logic [QIW-1:0] advance(input logic [QIW-1:0] s,
                                             input logic [QCW-1:0] n);
    logic [QCW-1:0] s1;
    begin
      s1 = QCW'(s) + QCW'(1);
      advance = (s1 >= n) ? '0 : QIW'(s1);
    end
  endfunction

  always_comb begin
    wr_slot_next = wr_slot;
    rd_slot_next = rd_slot;
    count_next   = count;
    if (cmd.clear) begin
      wr_slot_next = '0;
      rd_slot_next = '0;
      count_next   = '0;
    end else begin
      if (cmd.push) begin
        wr_slot_next = advance(wr_slot, eff_size);
        count_next   = count + FCW'(1);
      end
      if (cmd.pop) begin
        rd_slot_next = advance(rd_slot, eff_size);
        count_next   = count - FCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_slot <= '0;
      rd_slot <= '0;
      count   <= '0;
    end else begin
      wr_slot <= wr_slot_next;
      rd_slot <= rd_slot_next;
      count   <= count_next;
    end
  end

  // head always tracks the next read slot; a push into that slot bypasses
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_slot] <= push_data;
    end
    if (cmd.push && wr_slot == rd_slot_next) begin
      head <= push_data;
    end else begin
      head <= mem[rd_slot_next];
    end
  end

endmodule

@@ rtl/etdq_table.sv @@
// Event table: enable bits and bound-valid bits in flops, argument words in
// a memory with registered read. Depends on etdq_pkg.
module etdq_table import etdq_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ARG_WIDTH   = ARG_WIDTH_DEF,
  localparam int TIW = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tbl_cmd_t               cmd,
  input  logic [TIW-1:0]         wr_idx,
  input  logic [4*ARG_WIDTH-1:0] wr_args,
  input  logic [TIW-1:0]         rd_idx,
  output logic                   wr_enabled,
  output logic                   rd_enabled,
  output logic [4*ARG_WIDTH-1:0] rd_args
);

  logic [TABLE_DEPTH-1:0] enabled;
  logic [TABLE_DEPTH-1:0] bound;     // entry holds written args, else reads zero
  logic [4*ARG_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [4*ARG_WIDTH-1:0] rd_q;
  logic                   rd_keep;

  assign wr_enabled = enabled[wr_idx];
  assign rd_enabled = enabled[rd_idx];
  assign rd_args    = rd_keep ? rd_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
      bound   <= '0;
      rd_keep <= 1'b0;
    end else if (cmd.load) begin
      rd_keep <= cmd.rd_req && bound[rd_idx];
      unique case (cmd.op)
        TBL_BIND: begin
          enabled[wr_idx] <= 1'b0;
          bound[wr_idx]   <= 1'b1;
        end
        TBL_UNBIND: begin
          enabled[wr_idx] <= 1'b0;
          bound[wr_idx]   <= 1'b0;
        end
        TBL_ENABLE:  enabled[wr_idx] <= 1'b1;
        TBL_DISABLE: enabled[wr_idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && cmd.op == TBL_BIND) begin
      mem[wr_idx] <= wr_args;
    end
    if (cmd.load) begin
      rd_q <= mem[rd_idx];
    end
  end

endmodule
